### rtl/bsdc_pkg.sv
// Package for the broadcast sender dedupe counter.
// Holds the field widths, codes, reset values and the structs that pass along the cell row.
// Depends on nothing.
package bsdc_pkg;

    localparam int ADDR_W              = 48;
    localparam int RSSI_W              = 8;
    localparam int COUNT_OUT_W         = 7;
    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic [ADDR_W-1:0] BCAST_ADDR   = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [RSSI_W-1:0] THRESH_RESET = -8'sd70;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Search token that walks the cell row, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic              hit;
        logic [ADDR_W-1:0] addr;
    } probe_t;

    // Append command; the cell whose index equals the current count takes it.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } wr_t;

endpackage

### rtl/bsdc_frame_if.sv
// Handshake channel that carries one received frame or clear request per item.
// Depends on bsdc_pkg for the field widths.
interface bsdc_frame_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic                                is_mgmt;
    logic [bsdc_pkg::ADDR_W-1:0]         receiver_addr;
    logic [bsdc_pkg::ADDR_W-1:0]         sender_addr;
    logic signed [bsdc_pkg::RSSI_W-1:0]  rssi;

    modport source (
        output valid, op, is_mgmt, receiver_addr, sender_addr, rssi,
        input  ready
    );
    modport sink (
        input  valid, op, is_mgmt, receiver_addr, sender_addr, rssi,
        output ready
    );
endinterface

### rtl/bsdc_result_if.sv
// Handshake channel that carries one result item per accepted input item.
// Depends on bsdc_pkg for the field widths.
interface bsdc_result_if;
    logic                                valid;
    logic                                ready;
    logic [bsdc_pkg::COUNT_OUT_W-1:0]    distinct_count;
    logic                                added;
    logic                                duplicate;
    logic                                dropped_full;

    modport source (
        output valid, distinct_count, added, duplicate, dropped_full,
        input  ready
    );
    modport sink (
        input  valid, distinct_count, added, duplicate, dropped_full,
        output ready
    );
endinterface

### rtl/bsdc_cell.sv
// One cell of the sender table: holds a single stored address and compares the passing probe.
// Depends on bsdc_pkg for the probe and write structs.
module bsdc_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    count,
    input  bsdc_pkg::wr_t       wr,
    input  bsdc_pkg::probe_t    probe_in,
    output bsdc_pkg::probe_t    probe_out
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [bsdc_pkg::ADDR_W-1:0] entry_reg;
    logic                        active_reg;
    logic                        active_next;
    logic                        hit_reg;
    logic                        hit_next;
    logic [bsdc_pkg::ADDR_W-1:0] addr_reg;

    // The entry only takes part once it lies below the fill count.
    always_comb
    begin
        active_next = probe_in.active;
        hit_next    = probe_in.hit
                    | (probe_in.active && (count > MY_IDX) && (entry_reg == probe_in.addr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        addr_reg <= probe_in.addr;
        if (wr.en && (count == MY_IDX))
        begin
            entry_reg <= wr.addr;
        end
    end

    assign probe_out.active = active_reg;
    assign probe_out.hit    = hit_reg;
    assign probe_out.addr   = addr_reg;

endmodule

### rtl/bsdc_chain.sv
// Row of table cells linked by the probe path, cell 0 first.
// Depends on bsdc_pkg and bsdc_cell.
module bsdc_chain #(
    parameter int TABLE_DEPTH = bsdc_pkg::DEFAULT_TABLE_DEPTH,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_W-1:0]    count,
    input  bsdc_pkg::wr_t       wr,
    input  bsdc_pkg::probe_t    probe_in,
    output bsdc_pkg::probe_t    probe_out
);

    bsdc_pkg::probe_t link [0:TABLE_DEPTH];

    assign link[0] = probe_in;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            bsdc_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (count),
                .wr        (wr),
                .probe_in  (link[g]),
                .probe_out (link[g+1])
            );
        end
    endgenerate

    assign probe_out = link[TABLE_DEPTH];

endmodule

### rtl/broadcast_sender_dedupe_counter_core.sv
// Broadcast sender dedupe counter: top level with control, count, threshold and result register.
// Depends on bsdc_pkg, bsdc_frame_if, bsdc_result_if and bsdc_chain.
//
// Each input item is a received frame or a clear request, and each gives exactly one result
// item. A frame qualifies when it is a management frame sent to the broadcast address with a
// signal strength strictly above the programmed threshold (reset -70 dBm). A qualifying frame's
// sender is looked up in a table of distinct senders held in a row of TABLE_DEPTH cells: a
// search token enters the first cell and moves one cell per clock, each cell below the current
// fill count comparing its stored address as the token passes. When the token leaves the last
// cell the sender is either flagged as a duplicate, appended at the fill count, or dropped with
// dropped_full set when the table is already full. One item is handled at a time. A qualifying
// frame's result waits for the token to walk the whole cell row; a clear item or a frame that
// does not qualify goes straight to the done state. The input is ready again in the cycle after
// the result is loaded from the done state. The result sits in an output register, so
// the next item is accepted while an earlier result still waits to be taken; once that next
// item has finished as well, the block holds it and stalls its input until the waiting result
// is taken. The threshold is written through cfg_we and cfg_wdata, and should only be changed
// while the block is idle.
// Table entries need no reset: an entry is only compared once the fill count has passed it.
module broadcast_sender_dedupe_counter_core #(
    parameter int TABLE_DEPTH = bsdc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic signed [bsdc_pkg::RSSI_W-1:0]  cfg_wdata,
    bsdc_frame_if.sink                          frame,
    bsdc_result_if.source                       result
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EXT_W = CNT_W + bsdc_pkg::COUNT_OUT_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic signed [bsdc_pkg::RSSI_W-1:0]  thresh_reg;

    // Result of the item in flight, waiting for the output register.
    logic                                res_added_reg;
    logic                                res_added_next;
    logic                                res_dup_reg;
    logic                                res_dup_next;
    logic                                res_drop_reg;
    logic                                res_drop_next;

    // Output register.
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [bsdc_pkg::COUNT_OUT_W-1:0]    out_count_reg;
    logic                                out_added_reg;
    logic                                out_dup_reg;
    logic                                out_drop_reg;

    logic                                accept;
    logic                                qualifies;
    logic                                out_load;
    logic [EXT_W-1:0]                    count_ext;

    bsdc_pkg::probe_t                    probe_in;
    bsdc_pkg::probe_t                    probe_out;
    bsdc_pkg::wr_t                       wr;

    assign frame.ready = (state_reg == ST_IDLE);
    assign accept      = frame.valid && frame.ready;

    assign qualifies = frame.is_mgmt
                    && (frame.receiver_addr == bsdc_pkg::BCAST_ADDR)
                    && (frame.rssi > thresh_reg);

    // The token is launched on acceptance of a qualifying frame.
    assign probe_in.active = accept && (frame.op == bsdc_pkg::OP_FRAME) && qualifies;
    assign probe_in.hit    = 1'b0;
    assign probe_in.addr   = frame.sender_addr;

    // The cell at the current count takes the address when a new sender is stored.
    assign wr.en   = (state_reg == ST_SEARCH) && probe_out.active && !probe_out.hit
                  && (count_reg < FULL_COUNT);
    assign wr.addr = probe_out.addr;

    bsdc_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .count     (count_reg),
        .wr        (wr),
        .probe_in  (probe_in),
        .probe_out (probe_out)
    );

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_added_next = res_added_reg;
        res_dup_next   = res_dup_reg;
        res_drop_next  = res_drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_added_next = 1'b0;
                    res_dup_next   = 1'b0;
                    res_drop_next  = 1'b0;
                    if (frame.op == bsdc_pkg::OP_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (qualifies)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (probe_out.active)
                begin
                    state_next = ST_DONE;
                    if (probe_out.hit)
                    begin
                        res_dup_next = 1'b1;
                    end
                    else if (count_reg < FULL_COUNT)
                    begin
                        count_next     = CNT_W'(count_reg + 1'b1);
                        res_added_next = 1'b1;
                    end
                    else
                    begin
                        res_drop_next = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // The reported count is the fill count taken to the width of the result field.
    assign count_ext = EXT_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            thresh_reg    <= bsdc_pkg::THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_added_reg <= res_added_next;
        res_dup_reg   <= res_dup_next;
        res_drop_reg  <= res_drop_next;
        if (out_load)
        begin
            out_count_reg <= count_ext[bsdc_pkg::COUNT_OUT_W-1:0];
            out_added_reg <= res_added_reg;
            out_dup_reg   <= res_dup_reg;
            out_drop_reg  <= res_drop_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.distinct_count = out_count_reg;
    assign result.added          = out_added_reg;
    assign result.duplicate      = out_dup_reg;
    assign result.dropped_full   = out_drop_reg;

endmodule

### dv/bsdc_tally_checker.sv
// Scoreboard for the broadcast sender dedupe counter testbench: predicts every result item
// from the accepted input items and threshold writes, and compares it with what the block returns.
// Depends on bsdc_pkg and the channel interfaces bsdc_frame_if and bsdc_result_if.
module bsdc_tally_checker
    import bsdc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic signed [RSSI_W-1:0] cfg_wdata,
    bsdc_frame_if                    frame,
    bsdc_result_if                   result,
    output int                       mismatches,
    output int                       pending,
    output int                       checked,
    output int                       stored_total,
    output int                       repeats_total,
    output int                       lost_total,
    output int                       clears_total,
    output int                       peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] distinct_count;
        logic                   added;
        logic                   duplicate;
        logic                   dropped_full;
    } tally_t;

    // Shadow copy of the sender table, its fill level and the threshold register.
    logic [ADDR_W-1:0]        known_senders [TABLE_DEPTH];
    int unsigned              fill;
    logic signed [RSSI_W-1:0] threshold;
    tally_t                   awaited_tallies [$];

    // Applies one item to the shadow state and returns the result it should produce.
    function automatic tally_t tally_after_item(
        input logic                     op,
        input logic                     is_mgmt,
        input logic [ADDR_W-1:0]        rx_addr,
        input logic [ADDR_W-1:0]        tx_addr,
        input logic signed [RSSI_W-1:0] rssi
    );
        tally_t t;
        bit     found;
        t     = '0;
        found = 1'b0;
        if (op == OP_CLEAR) begin
            fill = 0;
        end else if (is_mgmt && rx_addr == BCAST_ADDR && rssi > threshold) begin
            for (int i = 0; i < fill; i++) begin
                if (known_senders[i] == tx_addr) begin
                    found = 1'b1;
                end
            end
            if (found) begin
                t.duplicate = 1'b1;
            end else if (fill < TABLE_DEPTH) begin
                known_senders[fill] = tx_addr;
                fill++;
                t.added = 1'b1;
            end else begin
                t.dropped_full = 1'b1;
            end
        end
        t.distinct_count = fill[COUNT_OUT_W-1:0];
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tally_t want;
        if (!rst_n) begin
            fill          = 0;
            threshold     = THRESH_RESET;
            awaited_tallies.delete();
            mismatches    = 0;
            checked       = 0;
            stored_total  = 0;
            repeats_total = 0;
            lost_total    = 0;
            clears_total  = 0;
            peak_fill     = 0;
            pending      <= 0;
        end else begin
            if (cfg_we) begin
                threshold = cfg_wdata;
            end

            // Results are retired before new items are predicted, so an early result is
            // never matched against the item accepted at the same edge.
            if (result.valid && result.ready) begin
                checked++;
                if (awaited_tallies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result item with nothing awaited: count %0d add %b dup %b drop %b",
                                 $realtime, result.distinct_count, result.added,
                                 result.duplicate, result.dropped_full);
                    end
                end else begin
                    want = awaited_tallies.pop_front();
                    if (result.distinct_count !== want.distinct_count ||
                        result.added !== want.added ||
                        result.duplicate !== want.duplicate ||
                        result.dropped_full !== want.dropped_full) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: expected count %0d add %b dup %b drop %b, got count %0d add %b dup %b drop %b",
                                     $realtime, want.distinct_count, want.added,
                                     want.duplicate, want.dropped_full,
                                     result.distinct_count, result.added,
                                     result.duplicate, result.dropped_full);
                        end
                    end
                end
            end

            if (frame.valid && frame.ready) begin
                want = tally_after_item(frame.op, frame.is_mgmt, frame.receiver_addr,
                                        frame.sender_addr, frame.rssi);
                awaited_tallies.push_back(want);
                stored_total  += want.added;
                repeats_total += want.duplicate;
                lost_total    += want.dropped_full;
                if (frame.op == OP_CLEAR) begin
                    clears_total++;
                end
                if (fill > peak_fill) begin
                    peak_fill = fill;
                end
            end

            pending <= awaited_tallies.size();
        end
    end

endmodule

### dv/tb.sv
// Top of the broadcast sender dedupe counter testbench: clock, reset, stimulus, receiver
// back-pressure, watchdog and verdict. Prediction and comparison live in bsdc_tally_checker.
// Depends on bsdc_pkg, bsdc_frame_if, bsdc_result_if, bsdc_tally_checker and the core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsdc_pkg::*;

    localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
    // Stimulus stops once this many input items have been taken, directed ones included.
    localparam int TOTAL_ITEMS    = 450;
    // Length of the deliberate receiver hold-off that makes the block back up.
    localparam int HOLD_CYCLES    = 300;
    // Quiet cycles allowed before the run is declared hung. The slowest legitimate quiet
    // stretch comes from the receiver hold-off, well under this.
    localparam int WATCHDOG_LIMIT = 3000;

    // Mixes of sender addresses used by the random phases.
    typedef enum int {
        FEW_SENDERS  = 0,   // a handful of senders, so most frames are repeats
        MANY_SENDERS = 1,   // a wider pool, with near-miss addresses one bit apart
        FILL_TABLE   = 2    // mostly fresh senders, driven past a full table
    } sender_mix_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic signed [RSSI_W-1:0] cfg_wdata;

    // Stimulus controls shared with the receiver process; past their initial values both are
    // written with nonblocking assignments so the receiver reads them without a race.
    logic idling;
    int   hold_reqs;

    // Threshold as last written, used only to aim the signal strength of generated frames.
    int thr_now;
    int items_sent;
    int threshold_writes;
    int phase;

    int mismatches;
    int pending;
    int checked;
    int stored_total;
    int repeats_total;
    int lost_total;
    int clears_total;
    int peak_fill;

    bsdc_frame_if  frame_ch ();
    bsdc_result_if result_ch ();

    broadcast_sender_dedupe_counter_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .frame    (frame_ch),
        .result   (result_ch)
    );

    bsdc_tally_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) tally_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .frame        (frame_ch),
        .result       (result_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked),
        .stored_total (stored_total),
        .repeats_total(repeats_total),
        .lost_total   (lost_total),
        .clears_total (clears_total),
        .peak_fill    (peak_fill)
    );

    always #10 clk = ~clk;

    // Gap lengths for both sides: usually a short gap, and one time in ten a long one that may
    // span a whole table walk.
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [ADDR_W-1:0] random_addr();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[ADDR_W-1:0];
    endfunction

    // Signal strength that passes the current threshold; a quarter of the time it sits
    // right on the boundary. With the threshold at its top nothing can pass.
    function automatic int rssi_above();
        int lo;
        if (thr_now >= 127)
        begin
            return int'($urandom_range(0, 255)) - 128;
        end
        lo = thr_now + 1;
        if ($urandom_range(0, 3) == 0)
        begin
            return lo;
        end
        return lo + int'($urandom_range(0, 127 - lo));
    endfunction

    // Signal strength that fails the threshold, often exactly equal to it.
    function automatic int rssi_at_or_below();
        if ($urandom_range(0, 3) == 0)
        begin
            return thr_now;
        end
        return -128 + int'($urandom_range(0, thr_now + 128));
    endfunction

    // Offers one item and returns at the edge where it is taken. Valid is left high so that
    // back-to-back items need no second assignment in the same time step; a gap lowers it.
    task automatic offer_item(
        input logic              op,
        input logic              is_mgmt,
        input logic [ADDR_W-1:0] rx_addr,
        input logic [ADDR_W-1:0] tx_addr,
        input int                rssi
    );
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = gap_length();
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid         <= 1'b1;
        frame_ch.op            <= op;
        frame_ch.is_mgmt       <= is_mgmt;
        frame_ch.receiver_addr <= rx_addr;
        frame_ch.sender_addr   <= tx_addr;
        frame_ch.rssi          <= rssi[RSSI_W-1:0];
        @(posedge clk);
        while (!frame_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic offer_clear();
        offer_item(OP_CLEAR, 1'($urandom_range(0, 1)), random_addr(), random_addr(),
                   int'($urandom_range(0, 255)));
    endtask

    task automatic offer_qualifying(input logic [ADDR_W-1:0] tx_addr);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, tx_addr, rssi_above());
    endtask

    // A frame that misses exactly one qualifying condition, or a fully random header.
    task automatic offer_noise();
        case ($urandom_range(0, 3))
            0: offer_item(OP_FRAME, 1'b0, BCAST_ADDR, random_addr(), rssi_above());
            1: offer_item(OP_FRAME, 1'b1, BCAST_ADDR ^ (48'd1 << $urandom_range(0, 47)),
                          random_addr(), rssi_above());
            2: offer_item(OP_FRAME, 1'($urandom_range(0, 1)), random_addr(), random_addr(),
                          int'($urandom_range(0, 255)));
            default: offer_item(OP_FRAME, 1'b1, BCAST_ADDR, random_addr(), rssi_at_or_below());
        endcase
    endtask

    // The threshold is only written with the block idle: input lowered, every result back,
    // then a further table walk's worth of cycles before the write.
    task automatic set_threshold(input int value);
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[RSSI_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        thr_now    = value;
        threshold_writes++;
    endtask

    // Hand-picked items at the reset threshold of -70 dBm: clears on an empty and a loaded
    // table, the address extremes, a one-bit near miss, each qualifying condition failed on
    // its own, signal strength on both sides of the boundary, and re-adding a sender that
    // was stored before a clear.
    task automatic directed_items();
        offer_clear();
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, '0, 127);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, '0, -69);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, BCAST_ADDR, -69);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, 48'h0000_0000_0001, 0);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, 48'h1234_5678_9ABC, -70);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, 48'h1234_5678_9ABC, -128);
        offer_item(OP_FRAME, 1'b0, BCAST_ADDR, 48'h1234_5678_9ABC, 127);
        offer_item(OP_FRAME, 1'b1, 48'hFFFF_FFFF_FFFE, 48'h1234_5678_9ABC, 127);
        offer_item(OP_FRAME, 1'b1, 48'h7FFF_FFFF_FFFF, 48'h1234_5678_9ABC, 127);
        offer_item(OP_FRAME, 1'b1, '0, 48'h1234_5678_9ABC, 127);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, 48'h0000_0000_0001, 5);
        offer_item(OP_CLEAR, 1'b1, BCAST_ADDR, 48'h1234_5678_9ABC, 127);
        offer_item(OP_CLEAR, 1'b0, '0, '0, -128);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, BCAST_ADDR, 127);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, BCAST_ADDR, -1);
        offer_item(OP_FRAME, 1'b1, BCAST_ADDR, '0, 1);
    endtask

    // One random phase: mostly qualifying frames drawn from a sender mix, with noise frames
    // and, outside the fill phases, an occasional clear. A fill phase starts from an empty
    // table and keeps adding fresh senders until well past full. A phase ends early once
    // the item budget of the run is spent.
    task automatic run_phase(input sender_mix_t mix, input int n, input bit with_hold);
        logic [ADDR_W-1:0] pool [$];
        logic [ADDR_W-1:0] tx_addr;
        int                pool_size;
        int                roll;
        if (mix != FILL_TABLE)
        begin
            pool_size = (mix == FEW_SENDERS) ? $urandom_range(1, 8)
                                             : $urandom_range(20, 60);
            for (int i = 0; i < pool_size; i++)
            begin
                // Some senders differ from the previous one in a single bit, so the whole
                // address has to be compared.
                if (i > 0 && $urandom_range(0, 9) < 3)
                begin
                    pool.push_back(pool[i-1] ^ (48'd1 << $urandom_range(0, 47)));
                end
                else
                begin
                    pool.push_back(random_addr());
                end
            end
        end
        else
        begin
            offer_clear();
        end
        for (int i = 0; i < n && items_sent < TOTAL_ITEMS; i++)
        begin
            if (with_hold && i == 10)
            begin
                hold_reqs <= hold_reqs + 1;
            end
            roll = $urandom_range(0, 99);
            if (mix != FILL_TABLE && roll < 3)
            begin
                offer_clear();
            end
            else if (roll < 18)
            begin
                offer_noise();
            end
            else
            begin
                if (mix == FILL_TABLE && (pool.size() == 0 || $urandom_range(0, 99) < 85))
                begin
                    tx_addr = random_addr();
                    pool.push_back(tx_addr);
                end
                else
                begin
                    tx_addr = pool[$urandom_range(0, pool.size() - 1)];
                end
                offer_qualifying(tx_addr);
            end
        end
    endtask

    // Receiver: ready is chosen afresh each cycle. A pending hold request turns into one
    // long hold-off counted here; otherwise random stalls apply while idling is on.
    initial
    begin : receiver
        int stall_left;
        int holds_served;
        stall_left      = 0;
        holds_served    = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (holds_served != hold_reqs)
            begin
                holds_served++;
                stall_left       = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 2) == 0)
            begin
                stall_left       = gap_length() - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any cycle in reset or with an item taken on either channel restarts the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (frame_ch.valid && frame_ch.ready) ||
                (result_ch.valid && result_ch.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timed out after %0d cycles with nothing taken", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        sender_mix_t mix;
        int          thr;
        int          n;

        frame_ch.valid         = 1'b0;
        frame_ch.op            = OP_FRAME;
        frame_ch.is_mgmt       = 1'b0;
        frame_ch.receiver_addr = '0;
        frame_ch.sender_addr   = '0;
        frame_ch.rssi          = '0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        idling                 = 1'b1;
        hold_reqs              = 0;
        thr_now                = int'(THRESH_RESET);
        items_sent             = 0;
        threshold_writes       = 0;
        rst_n                  = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        // The first phases pin the threshold at its extremes, its reset value and zero;
        // later ones pick it at random. Idling alternates so some phases run flat out, and
        // two phases carry the long receiver hold-off.
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            case (phase)
                0:
                begin
                    thr = -128;
                    mix = FEW_SENDERS;
                    n   = 60;
                end
                1:
                begin
                    thr = 127;
                    mix = FEW_SENDERS;
                    n   = 15;
                end
                2:
                begin
                    thr = -70;
                    mix = FILL_TABLE;
                    n   = 110;
                end
                3:
                begin
                    thr = 0;
                    mix = MANY_SENDERS;
                    n   = 70;
                end
                default:
                begin
                    mix = sender_mix_t'(phase % 3);
                    thr = ($urandom_range(0, 4) == 0) ? -128
                                                      : -100 + int'($urandom_range(0, 80));
                    n   = (mix == FILL_TABLE) ? 110 : $urandom_range(40, 80);
                end
            endcase
            set_threshold(thr);
            idling <= (phase % 2 == 0);
            run_phase(mix, n, phase == 0 || phase == 3);
            phase++;
        end

        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("Run covered %0d result items: %0d senders stored, %0d repeats,",
                 checked, stored_total, repeats_total);
        $display("%0d lost to a full table, %0d clears, threshold set %0d times; peak %0d of %0d.",
                 lost_total, clears_total, threshold_writes, peak_fill, TABLE_DEPTH);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### sim.f
rtl/bsdc_pkg.sv
rtl/bsdc_frame_if.sv
rtl/bsdc_result_if.sv
rtl/bsdc_cell.sv
rtl/bsdc_chain.sv
rtl/broadcast_sender_dedupe_counter_core.sv
dv/bsdc_tally_checker.sv
dv/tb.sv
